FILE: rtl/ggc_pkg.sv
// package for the go-to-goal pose controller
// fixed widths, constants, register codes and the cordic arctangent table
// no dependencies
`default_nettype none

package ggc_pkg;

  // fixed field widths
  localparam int HEAD_W     = 15;
  localparam int CMD_W      = 16;
  localparam int GAIN_W     = 8;
  localparam int DTOL_W     = 15;
  localparam int ATOL_W     = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // internal angle widths
  localparam int Z_W   = 21;   // cordic angle accumulator, rad * 2^16
  localparam int ANG_W = 17;   // bearing in q3.12 after rounding
  localparam int ERR_W = 18;   // heading error before and after wrapping

  // fixed point constants
  localparam int PI_Q16    = 205887;
  localparam int PRESCALE  = 8;
  localparam int GOAL_RST  = 5678;
  localparam int ANG_RND   = 8;
  localparam int MAG_SHIFT = 24;
  localparam int MAG_RND   = 1 << 23;

  // 1/K = 39797 / 2^16, split into two byte-wide partial products
  localparam logic [7:0] INV_GAIN_HI = 8'd155;
  localparam logic [7:0] INV_GAIN_LO = 8'd117;

  localparam logic signed [ERR_W-1:0] PI_Q12     = 18'sd12868;
  localparam logic signed [ERR_W-1:0] TWO_PI_Q12 = 18'sd25736;

  // reset values of the configuration registers
  localparam logic [GAIN_W-1:0] LIN_GAIN_RST = 8'd128;
  localparam logic [GAIN_W-1:0] ANG_GAIN_RST = 8'd128;
  localparam logic [DTOL_W-1:0] DIST_TOL_RST = 15'd102;
  localparam logic [ATOL_W-1:0] ANG_TOL_RST  = 14'd410;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIN_GAIN = 2'd0,
    REG_ANG_GAIN = 2'd1,
    REG_DIST_TOL = 2'd2,
    REG_ANG_TOL  = 2'd3
  } reg_idx_e;

  // atan(2^-i) in rad * 2^16
  function automatic logic [16:0] atan_q16(input logic [4:0] idx);
    logic [16:0] val;
    case (idx)
      5'd0:    val = 17'd51472;
      5'd1:    val = 17'd30385;
      5'd2:    val = 17'd16055;
      5'd3:    val = 17'd8150;
      5'd4:    val = 17'd4091;
      5'd5:    val = 17'd2047;
      5'd6:    val = 17'd1024;
      5'd7:    val = 17'd512;
      5'd8:    val = 17'd256;
      5'd9:    val = 17'd128;
      5'd10:   val = 17'd64;
      5'd11:   val = 17'd32;
      5'd12:   val = 17'd16;
      5'd13:   val = 17'd8;
      5'd14:   val = 17'd4;
      5'd15:   val = 17'd2;
      5'd16:   val = 17'd1;
      default: val = 17'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ggc_intf.sv
// handshake interfaces of the go-to-goal pose controller: pose in, command out, config
// depends on ggc_pkg
`default_nettype none

interface ggc_in_if import ggc_pkg::*; #(
  parameter int POS_WIDTH = 16
);
  logic                     valid;
  logic                     ready;
  logic signed [POS_WIDTH-1:0] pos_x;
  logic signed [POS_WIDTH-1:0] pos_y;
  logic signed [HEAD_W-1:0]    heading;
  logic                        new_goal_valid;
  logic signed [POS_WIDTH-1:0] goal_in_x;
  logic signed [POS_WIDTH-1:0] goal_in_y;

  modport source (output valid, pos_x, pos_y, heading, new_goal_valid, goal_in_x, goal_in_y,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, heading, new_goal_valid, goal_in_x, goal_in_y,
                  output ready);
endinterface

interface ggc_out_if import ggc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        linear_cmd;
  logic signed [CMD_W-1:0] angular_cmd;
  logic                    arrived;
  logic                    turning;

  modport source (output valid, linear_cmd, angular_cmd, arrived, turning, input ready);
  modport sink   (input valid, linear_cmd, angular_cmd, arrived, turning, output ready);
endinterface

interface ggc_cfg_if import ggc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/ggc_cordic.sv
// iterative cordic vectoring unit: bearing and scaled magnitude of (dx, dy)
// one shift-add step per cycle, then two byte partial products for 1/K; depends on ggc_pkg
`default_nettype none

module ggc_cordic import ggc_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int POS_WIDTH    = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  input  wire logic signed [POS_WIDTH:0] dx_i,
  input  wire logic signed [POS_WIDTH:0] dy_i,
  output logic                          done_o,
  output logic signed [ANG_W-1:0]       ang_o,
  output logic [POS_WIDTH+1:0]          dist_o
);

  localparam int XW = POS_WIDTH + 11;
  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int MW = XW + 15;
  localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_ITER = 4'b0010,
    C_MHI  = 4'b0100,
    C_MLO  = 4'b1000
  } cstate_e;

  cstate_e                 state_q, state_d;
  logic signed [XW-1:0]    x_q, x_d, y_q, y_d;
  logic signed [Z_W-1:0]   z_q, z_d;
  logic [IW-1:0]           step_q, step_d;
  logic [MW-1:0]           acc_q, acc_d;
  logic                    done_q, done_d;

  logic signed [XW-1:0]    x_pre, y_pre, xs, ys;
  logic signed [Z_W-1:0]   at, z_rnd;
  logic [XW-2:0]           x_u;

  assign x_pre = XW'(dx_i) <<< PRESCALE;
  assign y_pre = XW'(dy_i) <<< PRESCALE;
  assign xs    = x_q >>> step_q;
  assign ys    = y_q >>> step_q;
  assign at    = signed'(Z_W'(atan_q16(5'(step_q))));
  assign x_u   = x_q[XW-2:0];

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    step_d  = step_q;
    acc_d   = acc_q;
    done_d  = 1'b0;
    unique case (state_q)
      C_IDLE: begin
        if (start_i) begin
          // left half plane: pre-rotate by pi
          if (x_pre < 0) begin
            x_d = -x_pre;
            y_d = -y_pre;
            z_d = (y_pre >= 0) ? Z_W'(PI_Q16) : -Z_W'(PI_Q16);
          end else begin
            x_d = x_pre;
            y_d = y_pre;
            z_d = '0;
          end
          step_d  = '0;
          state_d = C_ITER;
        end
      end
      C_ITER: begin
        if (y_q >= 0) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + at;
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - at;
        end
        if (step_q == LAST_STEP) begin
          state_d = C_MHI;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      C_MHI: begin
        acc_d   = MW'(x_u) * MW'(INV_GAIN_HI);
        state_d = C_MLO;
      end
      C_MLO: begin
        acc_d   = (acc_q << 8) + MW'(x_u) * MW'(INV_GAIN_LO) + MW'(MAG_RND);
        done_d  = 1'b1;
        state_d = C_IDLE;
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    acc_q <= acc_d;
  end

  // bearing rounded half up to q3.12
  assign z_rnd  = z_q + Z_W'(ANG_RND);
  assign ang_o  = z_rnd[Z_W-1:4];
  assign dist_o = acc_q[MW-1:MAG_SHIFT];
  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: rtl/go_to_goal_pose_controller_top.sv
// top level of the go-to-goal pose controller for a unicycle robot
// holds the goal, sequences the cordic unit and forms the velocity commands
// depends on ggc_pkg, ggc_intf (interfaces) and ggc_cordic
//
// usage:
//   in_i   one word per control tick: pose (x, y, heading) and an optional new goal.
//          a set new_goal_valid loads the goal and arms the controller first
//   out_o  one word per accepted input: linear and angular command, arrived, turning
//   cfg_i  register writes (gains, distance and angle tolerance), always ready,
//          to be written only while no tick is in flight
// timing:
//   in_i.ready is high only while the sequencer is idle. a new word is not accepted while
//   the last one is in the prep, cordic, decide or cmd step, ready coming back together
//   with the result; the cordic loop does one shift-add step per cycle
// reset:
//   goal at 5678 (about 5.54 m) on both axes, controller disarmed, gains 0.5,
//   tolerances 0.1; nothing to clear beyond that
// stall:
//   the result sits in an output register, so the next word may be accepted
//   while it waits; a second result waits in the last step until out_o drains
`default_nettype none

module go_to_goal_pose_controller_top import ggc_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int POS_WIDTH    = 16
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  ggc_in_if.sink    in_i,
  ggc_cfg_if.sink   cfg_i,
  ggc_out_if.source out_o
);

  localparam int DW  = POS_WIDTH + 2;                 // distance width
  localparam int OPW = (DW > ERR_W) ? DW : ERR_W;     // shared multiplier operand

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PREP   = 5'b00010,
    S_CORDIC = 5'b00100,
    S_DECIDE = 5'b01000,
    S_CMD    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [GAIN_W-1:0] lin_gain_q, ang_gain_q;
  logic [DTOL_W-1:0] dist_tol_q;
  logic [ATOL_W-1:0] ang_tol_q;

  // goal store and the armed flag
  logic signed [POS_WIDTH-1:0] goal_x_q, goal_y_q;
  logic                        active_q, active_d;

  // captured pose
  logic signed [POS_WIDTH-1:0] pos_x_q, pos_y_q;
  logic signed [HEAD_W-1:0]    hd_q;

  // decision stage
  logic            dec_arr_q, dec_turn_q, dec_neg_q;
  logic [OPW-1:0]  op_q;

  // output register
  logic                    out_valid_q;
  logic [CMD_W-1:0]        lin_q;
  logic signed [CMD_W-1:0] angc_q;
  logic                    arr_q, turn_q;

  logic                    in_acc;
  logic                    out_load;
  logic                    cordic_done;
  logic signed [ANG_W-1:0] ang;
  logic [DW-1:0]           goal_dist;
  logic signed [POS_WIDTH:0] dx, dy;

  assign in_acc     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // goal minus pose at one bit of headroom
  assign dx = (POS_WIDTH+1)'(goal_x_q) - (POS_WIDTH+1)'(pos_x_q);
  assign dy = (POS_WIDTH+1)'(goal_y_q) - (POS_WIDTH+1)'(pos_y_q);

  ggc_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .POS_WIDTH    (POS_WIDTH)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_PREP),
    .dx_i    (dx),
    .dy_i    (dy),
    .done_o  (cordic_done),
    .ang_o   (ang),
    .dist_o  (goal_dist)
  );

  // heading error, wrapped once each way
  logic signed [ERR_W-1:0] err_raw, err_a, err;
  logic [ERR_W-1:0]        aerr;
  logic                    far, turn_sel;

  always_comb begin
    err_raw = ERR_W'(ang) - ERR_W'(hd_q);
    err_a   = (err_raw > PI_Q12) ? err_raw - TWO_PI_Q12 : err_raw;
    err     = (err_a < -PI_Q12) ? err_a + TWO_PI_Q12 : err_a;
    aerr    = (err < 0) ? ERR_W'(-err) : ERR_W'(err);
    far     = active_q && (OPW'(goal_dist) > OPW'(dist_tol_q));
    turn_sel = aerr > ERR_W'(ang_tol_q);
  end

  // one multiplier shared by both commands
  logic [OPW+GAIN_W-1:0] prod;
  logic [OPW-1:0]        prod_sh;
  logic [CMD_W-1:0]      mag, lin_sat;

  always_comb begin
    prod    = (OPW+GAIN_W)'(op_q) * (OPW+GAIN_W)'(dec_turn_q ? ang_gain_q : lin_gain_q);
    prod_sh = prod[OPW+GAIN_W-1:GAIN_W];
    mag     = prod_sh[CMD_W-1:0];
    lin_sat = (|prod_sh[OPW-1:CMD_W]) ? {CMD_W{1'b1}} : prod_sh[CMD_W-1:0];
  end

  assign out_load = (state_q == S_CMD) && (!out_valid_q || out_o.ready);

  // sequencer
  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.new_goal_valid) begin
            active_d = 1'b1;
          end
          state_d = S_PREP;
        end
      end
      S_PREP: state_d = S_CORDIC;
      S_CORDIC: begin
        if (cordic_done) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!far) begin
          active_d = 1'b0;
        end
        state_d = S_CMD;
      end
      S_CMD: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      goal_x_q    <= POS_WIDTH'(GOAL_RST);
      goal_y_q    <= POS_WIDTH'(GOAL_RST);
      lin_gain_q  <= LIN_GAIN_RST;
      ang_gain_q  <= ANG_GAIN_RST;
      dist_tol_q  <= DIST_TOL_RST;
      ang_tol_q   <= ANG_TOL_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      if (in_acc && in_i.new_goal_valid) begin
        goal_x_q <= in_i.goal_in_x;
        goal_y_q <= in_i.goal_in_y;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (reg_idx_e'(cfg_i.index))
          REG_LIN_GAIN: lin_gain_q <= cfg_i.data[GAIN_W-1:0];
          REG_ANG_GAIN: ang_gain_q <= cfg_i.data[GAIN_W-1:0];
          REG_DIST_TOL: dist_tol_q <= cfg_i.data[DTOL_W-1:0];
          REG_ANG_TOL:  ang_tol_q  <= cfg_i.data[ATOL_W-1:0];
          default:      lin_gain_q <= lin_gain_q;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pos_x_q <= in_i.pos_x;
      pos_y_q <= in_i.pos_y;
      hd_q    <= in_i.heading;
    end
    if (state_q == S_DECIDE) begin
      dec_arr_q  <= !far;
      dec_turn_q <= far && turn_sel;
      dec_neg_q  <= err < 0;
      op_q       <= (far && turn_sel) ? OPW'(aerr) : OPW'(goal_dist);
    end
    if (out_load) begin
      arr_q  <= dec_arr_q;
      turn_q <= dec_turn_q;
      lin_q  <= (dec_arr_q || dec_turn_q) ? '0 : lin_sat;
      angc_q <= !dec_turn_q ? '0 : (dec_neg_q ? -signed'(mag) : signed'(mag));
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.linear_cmd  = lin_q;
  assign out_o.angular_cmd = angc_q;
  assign out_o.arrived     = arr_q;
  assign out_o.turning     = turn_q;

  // the cordic unit only reports back while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_done |-> state_q == S_CORDIC)
    else $error("cordic done outside its wait step");

  // an accepted word always starts a cordic pass next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_PREP)
    else $error("accepted word did not start the sequence");

  // arrival and turning exclude each other, arrival zeroes both commands
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && arr_q |-> !turn_q && lin_q == '0 && angc_q == '0)
    else $error("arrived word carries a command");

  // turning in place never drives forward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && turn_q |-> lin_q == '0)
    else $error("turning word carries a linear command");

  // after an arrival decision the controller is disarmed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DECIDE && !far |=> !active_q)
    else $error("goal still armed after arrival");

endmodule

`default_nettype wire

FILE: test/go_to_goal_pose_controller_top_test.sv
`timescale 1ns / 100ps
// testbench for go_to_goal_pose_controller_top: directed pose table, then random ticks
// over several register settings, each command word checked against a local predictor or a pinned row
// depends on ggc_pkg, ggc_intf and the rtl of the controller
module go_to_goal_pose_controller_top_test;
  import ggc_pkg::*;

  localparam int CORDIC_STEPS   = 16;
  localparam int POS_WIDTH      = 16;
  // shortest spacing from one accepted word to the next at the top level
  localparam int TICK_CYCLES    = CORDIC_STEPS + 7;
  localparam int PHASE_ITEMS    = 150;
  localparam int NUM_PHASES     = 8;
  localparam int LONG_HOLD      = 300;
  // cycles without any handshake before the run is abandoned
  localparam int QUIET_LIMIT    = 3000;
  localparam int NUM_ROWS       = 23;
  localparam longint INV_GAIN_Q16 = 39797;

  // one pose word as offered on in_i
  typedef struct {
    logic signed [POS_WIDTH-1:0] pos_x;
    logic signed [POS_WIDTH-1:0] pos_y;
    logic signed [HEAD_W-1:0]    heading;
    logic                        new_goal;
    logic signed [POS_WIDTH-1:0] goal_x;
    logic signed [POS_WIDTH-1:0] goal_y;
  } pose_word_t;

  // one command word as seen on out_o
  typedef struct {
    logic [CMD_W-1:0]        lin;
    logic signed [CMD_W-1:0] ang;
    logic                    arrived;
    logic                    turning;
  } cmd_word_t;

  // directed row: pose and goal, and where the answer is obvious the expected word
  typedef struct {
    int px;
    int py;
    int hd;
    bit ng;
    int gx;
    int gy;
    bit pinned;
    int exp_lin;
    int exp_ang;
    int exp_arrived;
    int exp_turning;
  } pose_row_t;

  logic clk_i;
  logic rst_ni;

  ggc_in_if #(.POS_WIDTH(POS_WIDTH)) pose_if ();
  ggc_cfg_if cfg_if ();
  ggc_out_if cmd_if ();

  go_to_goal_pose_controller_top #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .POS_WIDTH   (POS_WIDTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pose_if),
    .cfg_i (cfg_if),
    .out_o (cmd_if)
  );

  // predictor copy of the block's registers and goal state, reset values
  logic [GAIN_W-1:0]           lin_gain_q  = LIN_GAIN_RST;
  logic [GAIN_W-1:0]           ang_gain_q  = ANG_GAIN_RST;
  logic [DTOL_W-1:0]           dist_tol_q  = DIST_TOL_RST;
  logic [ATOL_W-1:0]           ang_tol_q   = ANG_TOL_RST;
  logic signed [POS_WIDTH-1:0] goal_x_q    = POS_WIDTH'(GOAL_RST);
  logic signed [POS_WIDTH-1:0] goal_y_q    = POS_WIDTH'(GOAL_RST);
  logic                        goal_armed_q = 1'b0;

  // atan(2^-i), radians scaled by 2^16
  longint arctan_q16 [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                              256, 128, 64, 32, 16, 8, 4, 2};

  cmd_word_t cmd_expect_q [$];
  int        mismatch_count = 0;
  int        quiet_cycles   = 0;
  bit        idle_on        = 1'b0;
  int        hold_requests  = 0;
  int        holds_served   = 0;

  // directed ticks, walked in order straight after reset with reset register values
  pose_row_t directed_rows [NUM_ROWS] = '{
    // nothing armed yet: stop word whatever the pose
    '{0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0},
    '{32767, 32767, 12868, 0, 0, 0, 1, 0, 0, 1, 0},
    '{-32768, -32768, -12868, 0, -1, -1, 1, 0, 0, 1, 0},
    // goal placed on the robot: zero distance, arrives at once
    '{100, 200, 0, 1, 100, 200, 1, 0, 0, 1, 0},
    // flag cleared by the arrival above
    '{0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0},
    // longest diagonal, heading along the x axis, off the bearing: turn in place
    '{-32768, -32768, 0, 1, 32767, 32767, 0, 0, 0, 0, 0},
    // same goal, aimed along the diagonal: drive
    '{-32768, -32768, 3217, 0, 0, 0, 0, 0, 0, 0, 0},
    // left half plane below the axis: pre-rotation by minus pi
    '{32767, 32767, 0, 1, -32768, -32768, 0, 0, 0, 0, 0},
    // left half plane above the axis, heading at minus pi
    '{32767, -32768, -12868, 1, -32768, 32767, 0, 0, 0, 0, 0},
    // bearing of pi on the negative x axis
    '{0, 0, 12868, 1, -1000, 0, 0, 0, 0, 0, 0},
    '{0, 0, -12868, 0, 0, 0, 0, 0, 0, 0, 0},
    // headings beyond plus and minus pi, wrapped once
    '{0, 0, 16383, 1, 1000, 0, 0, 0, 0, 0, 0},
    '{0, 0, -16384, 0, 0, 0, 0, 0, 0, 0, 0},
    // around the angle tolerance
    '{0, 0, 410, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 411, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, -411, 0, 0, 0, 0, 0, 0, 0, 0},
    // around the distance tolerance
    '{0, 0, 0, 1, 102, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 1, 103, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 0},
    // goal on the robot at the corner of the range
    '{-32768, -32768, 5, 1, -32768, -32768, 1, 0, 0, 1, 0},
    '{-32768, 32767, -3217, 1, 32767, -32768, 0, 0, 0, 0, 0},
    '{5000, -7000, -1, 1, -20000, 30000, 0, 0, 0, 0, 0},
    '{-5000, 7000, 1, 0, 0, 0, 0, 0, 0, 0, 0}
  };

  // free-running clock, 12 ns
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int clip(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // gap length for either side: mostly none or short, now and then long
  function automatic int idle_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // vectoring pass on the goal offset: bearing in q3.12 and range in q5.10
  function automatic void cordic_vector(input longint dx, input longint dy,
                                        output longint bearing_q12,
                                        output longint range_q10);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    // offsets pre-scaled by 2^8 for headroom in the shifts
    x = dx * 256;
    y = dy * 256;
    z = 0;
    // left half plane: fold by pi, sign taken from y
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q16) : -longint'(PI_Q16);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_q16[i];
      end
    end
    bearing_q12 = (z + 8) >>> 4;
    // gain correction and undo of the pre-scale, rounded half up
    range_q10 = (x * INV_GAIN_Q16 + (longint'(1) <<< 23)) >>> 24;
  endfunction

  // command word for one accepted pose word; updates the goal state
  function automatic cmd_word_t predict_command(input pose_word_t w);
    cmd_word_t c;
    longint    bearing;
    longint    goal_dist;
    longint    err;
    longint    aerr;
    longint    mag;
    longint    turn;
    longint    fwd;
    if (w.new_goal) begin
      goal_x_q     = w.goal_x;
      goal_y_q     = w.goal_y;
      goal_armed_q = 1'b1;
    end
    cordic_vector(longint'(goal_x_q) - longint'(w.pos_x),
                  longint'(goal_y_q) - longint'(w.pos_y), bearing, goal_dist);
    err = bearing - longint'(w.heading);
    // one wrap each way only, headings beyond pi are taken as given
    if (err > longint'(PI_Q12)) err = err - longint'(TWO_PI_Q12);
    if (err < -longint'(PI_Q12)) err = err + longint'(TWO_PI_Q12);
    c.lin     = '0;
    c.ang     = '0;
    c.arrived = 1'b0;
    c.turning = 1'b0;
    if (goal_armed_q && goal_dist > longint'(dist_tol_q)) begin
      aerr = (err < 0) ? -err : err;
      if (aerr > longint'(ang_tol_q)) begin
        mag       = (aerr * longint'(ang_gain_q)) >>> 8;
        turn      = (err < 0) ? -mag : mag;
        c.ang     = turn[CMD_W-1:0];
        c.turning = 1'b1;
      end else begin
        fwd   = (goal_dist * longint'(lin_gain_q)) >>> 8;
        c.lin = (fwd > 65535) ? 16'hFFFF : fwd[CMD_W-1:0];
      end
    end else begin
      c.arrived    = 1'b1;
      goal_armed_q = 1'b0;
    end
    return c;
  endfunction

  // random tick: mostly aimed near the goal so that turning, driving and arrival all occur
  function automatic pose_word_t random_pose_word();
    pose_word_t w;
    int         gx;
    int         gy;
    int         px;
    int         py;
    int         r;
    longint     bearing;
    longint     goal_dist;
    w.new_goal = ($urandom_range(0, 99) < 30);
    // goal fields carry noise even when they are to be ignored
    w.goal_x   = POS_WIDTH'($urandom);
    w.goal_y   = POS_WIDTH'($urandom);
    if (w.new_goal && $urandom_range(0, 1) == 1) begin
      w.goal_x = POS_WIDTH'(int'($urandom_range(0, 8192)) - 4096);
      w.goal_y = POS_WIDTH'(int'($urandom_range(0, 8192)) - 4096);
    end
    gx = w.new_goal ? int'(w.goal_x) : int'(goal_x_q);
    gy = w.new_goal ? int'(w.goal_y) : int'(goal_y_q);
    r  = $urandom_range(0, 99);
    if (r < 15) begin
      px = int'(POS_WIDTH'($urandom));
      py = int'(POS_WIDTH'($urandom));
      px = int'($signed(POS_WIDTH'(px)));
      py = int'($signed(POS_WIDTH'(py)));
    end else if (r < 30) begin
      // corners of the position range
      px = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
      py = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
    end else if (r < 60) begin
      // close to the goal, across the distance tolerance
      px = clip(gx + int'($urandom_range(0, 400)) - 200, -32768, 32767);
      py = clip(gy + int'($urandom_range(0, 400)) - 200, -32768, 32767);
    end else begin
      px = clip(gx + int'($urandom_range(0, 16000)) - 8000, -32768, 32767);
      py = clip(gy + int'($urandom_range(0, 16000)) - 8000, -32768, 32767);
    end
    w.pos_x = POS_WIDTH'(px);
    w.pos_y = POS_WIDTH'(py);
    r = $urandom_range(0, 99);
    if (r < 40) begin
      // roughly facing the goal, across the angle tolerance
      cordic_vector(longint'(gx - px), longint'(gy - py), bearing, goal_dist);
      w.heading = HEAD_W'(clip(int'(bearing) + int'($urandom_range(0, 1200)) - 600,
                               -16384, 16383));
    end else if (r < 50) begin
      w.heading = HEAD_W'($urandom);
    end else begin
      w.heading = HEAD_W'(int'($urandom_range(0, 25736)) - 12868);
    end
    return w;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // offer one pose word, hold it until taken, then log the expected command word
  task automatic offer_pose(input pose_word_t w, input bit pinned, input cmd_word_t pinned_word);
    int        gap;
    cmd_word_t predicted;
    gap = idle_gap();
    if (gap > 0) begin
      pose_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pose_if.pos_x          = w.pos_x;
    pose_if.pos_y          = w.pos_y;
    pose_if.heading        = w.heading;
    pose_if.new_goal_valid = w.new_goal;
    pose_if.goal_in_x      = w.goal_x;
    pose_if.goal_in_y      = w.goal_y;
    pose_if.valid          = 1'b1;
    @(posedge clk_i);
    while (!pose_if.ready) @(posedge clk_i);
    // predictor always runs so that the goal state keeps step with the block
    predicted = predict_command(w);
    cmd_expect_q.push_back(pinned ? pinned_word : predicted);
    @(negedge clk_i);
  endtask

  // sender pause: nothing offered until every command word is back
  task automatic drain_commands();
    pose_if.valid = 1'b0;
    while (cmd_expect_q.size() != 0) @(negedge clk_i);
  endtask

  // register write; valid is left high so back-to-back writes do not toggle it
  task automatic write_reg(input reg_idx_e idx, input int value);
    cfg_if.index = idx;
    cfg_if.data  = value[CFG_DATA_W-1:0];
    cfg_if.valid = 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_LIN_GAIN: lin_gain_q = value[GAIN_W-1:0];
      REG_ANG_GAIN: ang_gain_q = value[GAIN_W-1:0];
      REG_DIST_TOL: dist_tol_q = value[DTOL_W-1:0];
      REG_ANG_TOL:  ang_tol_q  = value[ATOL_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // receiver: random stalls, plus one long hold-off on request to back the block up
  initial begin
    int stall;
    cmd_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (holds_served != hold_requests) begin
        cmd_if.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        holds_served++;
      end else begin
        stall = idle_gap();
        if (stall > 0) begin
          cmd_if.ready = 1'b0;
          repeat (stall) @(negedge clk_i);
        end else begin
          cmd_if.ready = 1'b1;
        end
      end
    end
  end

  // command word check against the oldest expectation, field by field
  always @(posedge clk_i) begin : check_cmd
    cmd_word_t want;
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      if (cmd_expect_q.size() == 0) begin
        flag_mismatch($sformatf("command word with none expected (lin %0d ang %0d)",
                                cmd_if.linear_cmd, cmd_if.angular_cmd));
      end else begin
        want = cmd_expect_q.pop_front();
        if (want.lin !== cmd_if.linear_cmd)
          flag_mismatch($sformatf("linear_cmd expected %0d got %0d",
                                  want.lin, cmd_if.linear_cmd));
        if (want.ang !== cmd_if.angular_cmd)
          flag_mismatch($sformatf("angular_cmd expected %0d got %0d",
                                  want.ang, cmd_if.angular_cmd));
        if (want.arrived !== cmd_if.arrived)
          flag_mismatch($sformatf("arrived expected %0b got %0b",
                                  want.arrived, cmd_if.arrived));
        if (want.turning !== cmd_if.turning)
          flag_mismatch($sformatf("turning expected %0b got %0b",
                                  want.turning, cmd_if.turning));
      end
    end
  end

  // watchdog: too long without any handshake on any channel ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pose_if.valid && pose_if.ready) || (cmd_if.valid && cmd_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    pose_row_t  row;
    pose_word_t w;
    cmd_word_t  pinned_word;
    int         lg;
    int         ag;
    int         dt;
    int         at;

    // every input known from time zero
    rst_ni                 = 1'b0;
    pose_if.valid          = 1'b0;
    pose_if.pos_x          = '0;
    pose_if.pos_y          = '0;
    pose_if.heading        = '0;
    pose_if.new_goal_valid = 1'b0;
    pose_if.goal_in_x      = '0;
    pose_if.goal_in_y      = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = '0;
    cfg_if.data            = '0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table with reset register values, no idling
    foreach (directed_rows[i]) begin
      row                 = directed_rows[i];
      w.pos_x             = POS_WIDTH'(row.px);
      w.pos_y             = POS_WIDTH'(row.py);
      w.heading           = HEAD_W'(row.hd);
      w.new_goal          = row.ng;
      w.goal_x            = POS_WIDTH'(row.gx);
      w.goal_y            = POS_WIDTH'(row.gy);
      pinned_word.lin     = CMD_W'(row.exp_lin);
      pinned_word.ang     = CMD_W'(row.exp_ang);
      pinned_word.arrived = row.exp_arrived[0];
      pinned_word.turning = row.exp_turning[0];
      offer_pose(w, row.pinned, pinned_word);
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_commands();
      case (ph)
        0: begin
          // top of the gain and distance tolerance ranges, angle tolerance at pi
          lg = 255; ag = 255; dt = 32767; at = 12868;
        end
        1: begin
          // all zero: any distance counts, any error turns
          lg = 0; ag = 0; dt = 0; at = 0;
        end
        2: begin
          lg = LIN_GAIN_RST; ag = ANG_GAIN_RST; dt = DIST_TOL_RST; at = ANG_TOL_RST;
        end
        7: begin
          lg = $urandom_range(0, 255); ag = $urandom_range(0, 255);
          dt = $urandom_range(0, 32767); at = $urandom_range(0, 12868);
        end
        default: begin
          // high linear gain for saturation, small tolerances so the goal is rarely reached
          lg = $urandom_range(128, 255); ag = $urandom_range(0, 255);
          dt = $urandom_range(0, 400); at = $urandom_range(0, 1500);
        end
      endcase
      write_reg(REG_LIN_GAIN, lg);
      write_reg(REG_ANG_GAIN, ag);
      write_reg(REG_DIST_TOL, dt);
      write_reg(REG_ANG_TOL, at);
      cfg_if.valid = 1'b0;
      idle_on = (ph % 3) != 0;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while the sender keeps offering
        if (ph == 3 && n == 10) hold_requests++;
        if (ph == 5 && n == PHASE_ITEMS / 2) drain_commands();
        offer_pose(random_pose_word(), 1'b0, pinned_word);
      end
    end

    drain_commands();
    repeat (2 * TICK_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
